@@ rtl/sst_pkg.sv @@
package sst_pkg;

   localparam int SLOT_COUNT = 16;
   localparam int CODE_WIDTH = 8;

   localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
   localparam int CODE_FIELD_W = 8;
   localparam int POS_W  = 4;
   localparam int OCC_W  = 5;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_FIND   = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef logic [CODE_WIDTH-1:0] code_type;
   typedef logic [SLOT_COUNT-1:0] slot_vec_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [CODE_FIELD_W-1:0] item_code;
   } request_type;

   typedef struct packed {
      logic             ok;
      logic [POS_W-1:0] position;
      logic [OCC_W-1:0] occupied;
   } result_type;

   // lowest set bit of the vector, 0 when none
   function automatic logic [IDX_W-1:0] first_set(input slot_vec_type v);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (v[i]) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

@@ rtl/sst_slot_array.sv @@
module sst_slot_array (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  sst_pkg::request_type request,
   output sst_pkg::result_type  result
);
   import sst_pkg::*;

   code_type         slots_ff [SLOT_COUNT];
   code_type         slots_in [SLOT_COUNT];
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;

   code_type         code;
   logic             code_nz;
   logic             full;
   slot_vec_type     ge_vec;
   slot_vec_type     gt_vec;
   slot_vec_type     eq_vec;
   logic             found;
   logic [IDX_W-1:0] ins_idx;
   logic [IDX_W-1:0] match_idx;
   code_type         add_slots [SLOT_COUNT];
   code_type         rm_slots  [SLOT_COUNT];
   code_type         prev_slot [SLOT_COUNT];
   code_type         next_slot [SLOT_COUNT];
   logic             prev_ge   [SLOT_COUNT];

   assign code    = CODE_WIDTH'(request.item_code);
   assign code_nz = (code != '0);
   assign full    = (cnt_ff == CNT_W'(SLOT_COUNT));

   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         ge_vec[i] = (slots_ff[i] != '0) && (slots_ff[i] >= code);
         gt_vec[i] = (slots_ff[i] > code);
         eq_vec[i] = (slots_ff[i] == code);
      end
   end

   always_comb begin
      prev_slot[0] = '0;
      prev_ge[0]   = 1'b1;
      for (int i = 1; i < SLOT_COUNT; i++) begin
         prev_slot[i] = slots_ff[i-1];
         prev_ge[i]   = ge_vec[i-1];
      end
      next_slot[SLOT_COUNT-1] = '0;
      for (int i = 0; i < SLOT_COUNT - 1; i++) begin
         next_slot[i] = slots_ff[i+1];
      end
   end

   // add: larger or equal codes stay, new code lands after them, rest move down
   // remove: larger codes stay, rest move up over the emptied slot
   always_comb begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (ge_vec[i]) begin
            add_slots[i] = slots_ff[i];
         end else if (prev_ge[i]) begin
            add_slots[i] = code;
         end else begin
            add_slots[i] = prev_slot[i];
         end
         rm_slots[i] = gt_vec[i] ? slots_ff[i] : next_slot[i];
      end
   end

   assign found     = |eq_vec;
   assign ins_idx   = first_set(~ge_vec);
   assign match_idx = first_set(eq_vec);

   always_comb begin
      slots_in        = slots_ff;
      cnt_in          = cnt_ff;
      result.ok       = 1'b0;
      result.position = '0;
      unique case (request.cmd)
         CMD_ADD: begin
            if (!full) begin
               slots_in        = add_slots;
               cnt_in          = cnt_ff + CNT_W'(code_nz);
               result.ok       = 1'b1;
               result.position = POS_W'(ins_idx);
            end
         end
         CMD_REMOVE: begin
            if (found) begin
               slots_in        = rm_slots;
               cnt_in          = cnt_ff - CNT_W'(code_nz);
               result.ok       = 1'b1;
               result.position = POS_W'(match_idx);
            end
         end
         CMD_FIND: begin
            if (found) begin
               result.ok       = 1'b1;
               result.position = POS_W'(match_idx);
            end
         end
         CMD_CLEAR: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               slots_in[i] = '0;
            end
            cnt_in    = '0;
            result.ok = 1'b1;
         end
         default: begin
            slots_in = slots_ff;
         end
      endcase
      result.occupied = OCC_W'(cnt_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slots_ff[i] <= '0;
         end
         cnt_ff <= '0;
      end else if (step_en) begin
         slots_ff <= slots_in;
         cnt_ff   <= cnt_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(SLOT_COUNT))
      else $error("occupancy count beyond table size");

   assert property (@(posedge clock) disable iff (reset)
      (slots_ff[SLOT_COUNT-1] != '0) == (cnt_ff == CNT_W'(SLOT_COUNT)))
      else $error("last slot disagrees with occupancy count");

   assert property (@(posedge clock) disable iff (reset)
      (slots_ff[0] == '0) == (cnt_ff == '0))
      else $error("first slot disagrees with occupancy count");

   assert property (@(posedge clock) disable iff (reset)
      step_en && request.cmd == CMD_CLEAR |=> cnt_ff == '0 && slots_ff[0] == '0)
      else $error("table not empty after clear");

   genvar g;
   generate
      for (g = 0; g < SLOT_COUNT - 1; g++) begin : g_order
         assert property (@(posedge clock) disable iff (reset)
            slots_ff[g] >= slots_ff[g+1])
            else $error("slots out of descending order");
      end
   endgenerate

endmodule

@@ rtl/sorted_slot_table_core.sv @@
// An accepted item is held in the request register; its result is captured in
// the response register. Throughput: one item per cycle while the response is
// not stalled; table update and result are formed combinationally in between.
// Reset: synchronous, clears every slot to empty and drops both registers'
// valid flags.
module sorted_slot_table_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // cmd[1:0], item_code[9:2], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // ok[0], position[4:1], occupied[9:5], zero pad
);
   import sst_pkg::*;

   logic        req_valid_ff;
   logic        req_valid_in;
   request_type req_data_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   result_type  rsp_data_ff;
   result_type  step_result;
   logic        advance;
   request_type req_item;

   assign req_item.cmd       = cmd_type'(req_tdata[1:0]);
   assign req_item.item_code = req_tdata[9:2];

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   assign req_valid_in = (req_tvalid && req_tready) || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   sst_slot_array u_slots (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .request (req_data_ff),
      .result  (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_data_ff <= req_item;
      end
      if (advance) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff.occupied, rsp_data_ff.position, rsp_data_ff.ok};

endmodule
